// ===== rtl/core/lane_map_pixel_classifier_assert.svh =====
// Assertion macros shared by the lane map pixel classifier RTL.
`ifndef LANE_MAP_PIXEL_CLASSIFIER_ASSERT_SVH
`define LANE_MAP_PIXEL_CLASSIFIER_ASSERT_SVH

// Both macros sample on i_clk and are switched off while i_rst_n is low.
`define LMPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define LMPC_ASSERT_DLY(label, n, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lmpc_pkg.sv =====
// Types, constants and the exp fraction table of the lane map pixel classifier.
`timescale 1ns / 1ps
`default_nettype none

package lmpc_pkg;

    localparam int LOGIT_W    = 16;
    localparam int ROW_W      = 12;
    localparam int HEIGHT_W   = 13;
    localparam int PROB_W     = 16;
    localparam int CLASS_W    = 2;
    localparam int NUM_CLASS  = 4;
    localparam int EXP_W      = 17;
    localparam int U_W        = 17;
    localparam int PROD_W     = 34;
    localparam int FRAC_BITS  = 8;
    localparam int FRAC_ENTRIES = 256;
    localparam int SHIFT_W    = U_W - FRAC_BITS;
    localparam int SUM_W      = 19;
    localparam int NUM_W      = 34;
    localparam int DEN_W      = 19;
    localparam int QUO_W      = 17;
    localparam int REM_W      = 35;
    localparam int DIV_STAGES = QUO_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OMIT_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESH = 2'd2;

    localparam logic [HEIGHT_W-1:0] MAP_HEIGHT_RST   = 13'd480;
    localparam logic [ROW_W-1:0]    OMIT_ROWS_RST    = 12'd0;
    localparam logic [PROB_W-1:0]   SCORE_THRESH_RST = 16'd32768;

    localparam logic [CLASS_W-1:0] CLASS_BG = 2'd0;

    localparam logic [EXP_W-1:0]  ONE_Q16   = 17'h10000;
    localparam logic [EXP_W-1:0]  HALF_Q16  = 17'h08000;
    localparam logic [U_W-1:0]    LOG2E_Q16 = 17'd94548;
    localparam logic [NUM_W-1:0]  ONE_Q32   = 34'h1_0000_0000;
    localparam logic [SHIFT_W-1:0] EXP_MAX_SHIFT = 9'd16;
    localparam logic [PROB_W-1:0] PROB_SAT  = 16'hFFFF;

    // Q0.16 values of 2^(-2^b/256), entry b for fraction bit b.
    localparam logic [FRAC_BITS-1:0][15:0] POW2_FRAC = {
        16'd46341, 16'd55109, 16'd60097, 16'd62757,
        16'd64132, 16'd64830, 16'd65182, 16'd65359
    };

    typedef logic [FRAC_ENTRIES-1:0][EXP_W-1:0] t_frac_tab;

    // Builds 2^(-f/256) for every fraction f, rounding after each factor
    // in the order from fraction bit 0 upward.
    function automatic t_frac_tab build_frac_tab();
        t_frac_tab tab;
        logic [63:0] v;
        logic [FRAC_BITS-1:0] fb;
        for (int f = 0; f < FRAC_ENTRIES; f++) begin
            fb = FRAC_BITS'(f);
            v = 64'(ONE_Q16);
            for (int b = 0; b < FRAC_BITS; b++) begin
                if (fb[b]) begin
                    v = (v * 64'(POW2_FRAC[b]) + 64'(HALF_Q16)) >> 16;
                end
            end
            tab[f] = v[EXP_W-1:0];
        end
        return tab;
    endfunction

    localparam t_frac_tab EXP_FRAC_TAB = build_frac_tab();

    typedef struct packed {
        logic               valid;
        logic [CLASS_W-1:0] cls;
        logic               row_ok;
        logic               neg_l;
        logic               neg_r;
    } t_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/lmpc_exp.sv =====
// Two-stage exp(-k/256) unit: log2(e) scaling, then fraction table and shift.
`timescale 1ns / 1ps
`default_nettype none

module lmpc_exp (
    input  logic                         i_clk,
    input  logic [lmpc_pkg::LOGIT_W-1:0] i_k,
    output logic [lmpc_pkg::EXP_W-1:0]   o_e
);
    import lmpc_pkg::*;

    logic [PROD_W-1:0]  w_prod;
    logic [U_W-1:0]     r_u;
    logic [SHIFT_W-1:0] w_shift;
    logic [EXP_W-1:0]   n_e;
    logic [EXP_W-1:0]   r_e;

    assign w_prod = PROD_W'(i_k) * PROD_W'(LOG2E_Q16) + PROD_W'(HALF_Q16);

    always_ff @(posedge i_clk) begin
        r_u <= w_prod[16 +: U_W];
    end

    // Integer part of the exponent shifts the fraction value down.
    assign w_shift = r_u[U_W-1:FRAC_BITS];

    always_comb begin
        if (w_shift > EXP_MAX_SHIFT) begin
            n_e = '0;
        end else begin
            n_e = EXP_FRAC_TAB[r_u[FRAC_BITS-1:0]] >> w_shift[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_e <= n_e;
    end

    assign o_e = r_e;

endmodule

`default_nettype wire

// ===== rtl/core/lmpc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module lmpc_div (
    input  logic                       i_clk,
    input  logic [lmpc_pkg::NUM_W-1:0] i_num,
    input  logic [lmpc_pkg::DEN_W-1:0] i_den,
    output logic [lmpc_pkg::QUO_W-1:0] o_quo
);
    import lmpc_pkg::*;

    localparam int LAST = DIV_STAGES - 1;

    logic [REM_W-1:0] r_rem [LAST];
    logic [DEN_W-1:0] r_den [LAST];
    logic [QUO_W-1:0] r_quo [DIV_STAGES];

    // The quotient is known to stay below 2^QUO_W, so the first stage
    // starts from the top quotient bit with the whole dividend.
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_step
        logic [REM_W-1:0] src_rem;
        logic [REM_W-1:0] shifted;
        logic [DEN_W-1:0] src_den;
        logic [QUO_W-1:0] src_quo;
        logic             fits;

        if (j == 0) begin : g_head
            assign src_rem = REM_W'(i_num);
            assign src_den = i_den;
            assign src_quo = '0;
        end else begin : g_body
            assign src_rem = r_rem[j-1];
            assign src_den = r_den[j-1];
            assign src_quo = r_quo[j-1];
        end

        assign shifted = REM_W'(src_den) << (LAST - j);
        assign fits    = (src_rem >= shifted);

        always_ff @(posedge i_clk) begin
            r_quo[j] <= fits ? (src_quo | (QUO_W'(1) << (LAST - j))) : src_quo;
        end

        if (j < LAST) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[j] <= fits ? (src_rem - shifted) : src_rem;
                r_den[j] <= src_den;
            end
        end
    end

    assign o_quo = r_quo[LAST];

endmodule

`default_nettype wire

// ===== rtl/core/lane_map_pixel_classifier.sv =====
// Top level of the lane map pixel classifier pipeline.
//
// Usage: drive one pixel on the input ports with start high; the item is
// taken at that clock edge. busy stays low, so an item may enter at every
// clock edge and the block sustains one pixel per cycle.
// The result of each item is on the result ports, marked by o_strobe, for a
// single cycle. Results leave in the order the items came in; the receiver
// cannot stall the block and takes every result in its strobe cycle.
// The depth is set by the three 17-stage dividers (softmax probability and
// both sigmoids), one quotient bit per stage, plus argmax, exp and sum stages.
// Configuration: a write channel with i_cfg_valid / o_cfg_ready, register
// index on i_cfg_index (0 map height, 1 omitted rows, 2 score threshold)
// and data on i_cfg_data. o_cfg_ready is always high. Write only while no
// item is in flight.
// Reset (i_rst_n low, synchronous) empties the pipeline, drops o_strobe and
// loads the register defaults: height 480, no omitted rows, threshold 0.5.
`timescale 1ns / 1ps
`default_nettype none

`include "lane_map_pixel_classifier_assert.svh"

module lane_map_pixel_classifier #(
    parameter int MAX_ROWS = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [lmpc_pkg::ROW_W-1:0]      i_row,
    input  logic signed [lmpc_pkg::LOGIT_W-1:0] i_class0_logit,
    input  logic signed [lmpc_pkg::LOGIT_W-1:0] i_class1_logit,
    input  logic signed [lmpc_pkg::LOGIT_W-1:0] i_class2_logit,
    input  logic signed [lmpc_pkg::LOGIT_W-1:0] i_class3_logit,
    input  logic signed [lmpc_pkg::LOGIT_W-1:0] i_left_logit,
    input  logic signed [lmpc_pkg::LOGIT_W-1:0] i_right_logit,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lmpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lmpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_strobe,
    output logic                            o_lane_flag,
    output logic [lmpc_pkg::CLASS_W-1:0]    o_lane_class,
    output logic [lmpc_pkg::PROB_W-1:0]     o_sig_left,
    output logic [lmpc_pkg::PROB_W-1:0]     o_sig_right,
    output logic [lmpc_pkg::PROB_W-1:0]     o_score
);
    import lmpc_pkg::*;

    localparam int S_EXP_OUT  = 4;
    localparam int S_DIV_IN   = 6;
    localparam int CTL_LAST   = S_DIV_IN + DIV_STAGES;
    localparam int RESULT_LAT = CTL_LAST + 2;
    localparam int HEIGHT_MAX = (1 << HEIGHT_W) - 1;
    localparam int HEIGHT_CAP = (MAX_ROWS > HEIGHT_MAX) ? HEIGHT_MAX : MAX_ROWS;
    localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = HEIGHT_W'(HEIGHT_CAP);

    logic                accept;

    logic [HEIGHT_W-1:0] r_map_height;
    logic [ROW_W-1:0]    r_omit_rows;
    logic [PROB_W-1:0]   r_score_thresh;

    // Stage 0: input capture.
    logic                       r_s0_valid;
    logic [ROW_W-1:0]           r_s0_row;
    logic signed [LOGIT_W-1:0]  r_s0_logit [NUM_CLASS];
    logic signed [LOGIT_W-1:0]  r_s0_left;
    logic signed [LOGIT_W-1:0]  r_s0_right;

    // Stage 1: argmax, row window, magnitudes.
    logic                       lo_sel;
    logic                       hi_sel;
    logic                       top_sel;
    logic signed [LOGIT_W-1:0]  lo_max;
    logic signed [LOGIT_W-1:0]  hi_max;
    logic [HEIGHT_W-1:0]        height;
    logic [HEIGHT_W-1:0]        row_sum;
    t_ctl                       n_s1_ctl;
    logic signed [LOGIT_W-1:0]  n_s1_max;
    logic signed [LOGIT_W-1:0]  r_s1_max;
    logic signed [LOGIT_W-1:0]  r_s1_logit [NUM_CLASS];
    logic [LOGIT_W-1:0]         r_s1_mag_l;
    logic [LOGIT_W-1:0]         r_s1_mag_r;

    // Stage 2: exp arguments.
    logic [LOGIT_W-1:0]         r_s2_k [NUM_CLASS];
    logic [LOGIT_W-1:0]         r_s2_mag_l;
    logic [LOGIT_W-1:0]         r_s2_mag_r;

    // Stages 3 and 4 sit inside the exp units.
    logic [EXP_W-1:0]           w_cls_e [NUM_CLASS];
    logic [EXP_W-1:0]           w_e_l;
    logic [EXP_W-1:0]           w_e_r;

    // Stage 5: softmax sum.
    logic [SUM_W-1:0]           r_s5_sum;
    logic [EXP_W-1:0]           r_s5_e_l;
    logic [EXP_W-1:0]           r_s5_e_r;

    // Stage 6: divider operands.
    logic [DEN_W-1:0]           n_s6_den_l;
    logic [DEN_W-1:0]           n_s6_den_r;
    logic [NUM_W-1:0]           r_s6_num_p;
    logic [DEN_W-1:0]           r_s6_den_p;
    logic [NUM_W-1:0]           r_s6_num_l;
    logic [DEN_W-1:0]           r_s6_den_l;
    logic [NUM_W-1:0]           r_s6_num_r;
    logic [DEN_W-1:0]           r_s6_den_r;

    logic [QUO_W-1:0]           w_q_p;
    logic [QUO_W-1:0]           w_q_l;
    logic [QUO_W-1:0]           w_q_r;

    t_ctl                       r_ctl [1:CTL_LAST];

    logic                       n_lane;
    logic                       r_strobe;
    logic                       r_out_flag;
    logic [CLASS_W-1:0]         r_out_class;
    logic [PROB_W-1:0]          r_out_left;
    logic [PROB_W-1:0]          r_out_right;
    logic [PROB_W-1:0]          r_out_score;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_height   <= MAP_HEIGHT_RST;
            r_omit_rows    <= OMIT_ROWS_RST;
            r_score_thresh <= SCORE_THRESH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MAP_HEIGHT:   r_map_height   <= i_cfg_data[HEIGHT_W-1:0];
                CFG_OMIT_ROWS:    r_omit_rows    <= i_cfg_data[ROW_W-1:0];
                CFG_SCORE_THRESH: r_score_thresh <= i_cfg_data[PROB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Stage 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_row      <= i_row;
        r_s0_logit[0] <= i_class0_logit;
        r_s0_logit[1] <= i_class1_logit;
        r_s0_logit[2] <= i_class2_logit;
        r_s0_logit[3] <= i_class3_logit;
        r_s0_left     <= i_left_logit;
        r_s0_right    <= i_right_logit;
    end

    // Stage 1: a tie keeps the lower class index at every level of the tree.
    always_comb begin
        lo_sel   = (r_s0_logit[1] > r_s0_logit[0]);
        hi_sel   = (r_s0_logit[3] > r_s0_logit[2]);
        lo_max   = lo_sel ? r_s0_logit[1] : r_s0_logit[0];
        hi_max   = hi_sel ? r_s0_logit[3] : r_s0_logit[2];
        top_sel  = (hi_max > lo_max);
        n_s1_max = top_sel ? hi_max : lo_max;

        height  = (r_map_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : r_map_height;
        row_sum = HEIGHT_W'(r_s0_row) + HEIGHT_W'(r_omit_rows);

        n_s1_ctl.valid  = r_s0_valid;
        n_s1_ctl.cls    = top_sel ? {1'b1, hi_sel} : {1'b0, lo_sel};
        n_s1_ctl.row_ok = (row_sum < height);
        n_s1_ctl.neg_l  = r_s0_left[LOGIT_W-1];
        n_s1_ctl.neg_r  = r_s0_right[LOGIT_W-1];
    end

    always_ff @(posedge i_clk) begin
        r_s1_max   <= n_s1_max;
        r_s1_logit <= r_s0_logit;
        r_s1_mag_l <= r_s0_left[LOGIT_W-1] ? LOGIT_W'(-r_s0_left) : LOGIT_W'(r_s0_left);
        r_s1_mag_r <= r_s0_right[LOGIT_W-1] ? LOGIT_W'(-r_s0_right) : LOGIT_W'(r_s0_right);
    end

    // Stage 2: distance of each logit below the maximum fits 16 bits unsigned.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_CLASS; i++) begin
            r_s2_k[i] <= LOGIT_W'(r_s1_max - r_s1_logit[i]);
        end
        r_s2_mag_l <= r_s1_mag_l;
        r_s2_mag_r <= r_s1_mag_r;
    end

    // Stages 3 and 4.
    for (genvar c = 0; c < NUM_CLASS; c++) begin : g_cls_exp
        lmpc_exp u_exp (
            .i_clk (i_clk),
            .i_k   (r_s2_k[c]),
            .o_e   (w_cls_e[c])
        );
    end

    lmpc_exp u_exp_left (
        .i_clk (i_clk),
        .i_k   (r_s2_mag_l),
        .o_e   (w_e_l)
    );

    lmpc_exp u_exp_right (
        .i_clk (i_clk),
        .i_k   (r_s2_mag_r),
        .o_e   (w_e_r)
    );

    // Stage 5.
    always_ff @(posedge i_clk) begin
        r_s5_sum <= (SUM_W'(w_cls_e[0]) + SUM_W'(w_cls_e[1]))
                  + (SUM_W'(w_cls_e[2]) + SUM_W'(w_cls_e[3]));
        r_s5_e_l <= w_e_l;
        r_s5_e_r <= w_e_r;
    end

    // Stage 6: rounded quotients take half the divisor onto the dividend.
    assign n_s6_den_l = DEN_W'(ONE_Q16) + DEN_W'(r_s5_e_l);
    assign n_s6_den_r = DEN_W'(ONE_Q16) + DEN_W'(r_s5_e_r);

    always_ff @(posedge i_clk) begin
        r_s6_num_p <= ONE_Q32 + NUM_W'(r_s5_sum >> 1);
        r_s6_den_p <= DEN_W'(r_s5_sum);
        r_s6_num_l <= (r_ctl[5].neg_l ? NUM_W'({r_s5_e_l, 16'h0000}) : ONE_Q32)
                    + NUM_W'(n_s6_den_l >> 1);
        r_s6_den_l <= n_s6_den_l;
        r_s6_num_r <= (r_ctl[5].neg_r ? NUM_W'({r_s5_e_r, 16'h0000}) : ONE_Q32)
                    + NUM_W'(n_s6_den_r >> 1);
        r_s6_den_r <= n_s6_den_r;
    end

    // Stages 7 to 23.
    lmpc_div u_div_prob (
        .i_clk (i_clk),
        .i_num (r_s6_num_p),
        .i_den (r_s6_den_p),
        .o_quo (w_q_p)
    );

    lmpc_div u_div_left (
        .i_clk (i_clk),
        .i_num (r_s6_num_l),
        .i_den (r_s6_den_l),
        .o_quo (w_q_l)
    );

    lmpc_div u_div_right (
        .i_clk (i_clk),
        .i_num (r_s6_num_r),
        .i_den (r_s6_den_r),
        .o_quo (w_q_r)
    );

    // Control travels beside the data through every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= CTL_LAST; s++) begin
                r_ctl[s] <= '0;
            end
        end else begin
            r_ctl[1] <= n_s1_ctl;
            for (int s = 2; s <= CTL_LAST; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    // Output stage: the threshold sees the probability before saturation.
    assign n_lane = (r_ctl[CTL_LAST].cls != CLASS_BG)
                 && (w_q_p >= QUO_W'(r_score_thresh))
                 && r_ctl[CTL_LAST].row_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_ctl[CTL_LAST].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_lane) begin
            r_out_flag  <= 1'b1;
            r_out_class <= r_ctl[CTL_LAST].cls;
            r_out_left  <= w_q_l[PROB_W] ? PROB_SAT : w_q_l[PROB_W-1:0];
            r_out_right <= w_q_r[PROB_W] ? PROB_SAT : w_q_r[PROB_W-1:0];
            r_out_score <= w_q_p[PROB_W] ? PROB_SAT : w_q_p[PROB_W-1:0];
        end else begin
            r_out_flag  <= 1'b0;
            r_out_class <= CLASS_BG;
            r_out_left  <= '0;
            r_out_right <= '0;
            r_out_score <= '0;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_lane_flag  = r_out_flag;
    assign o_lane_class = r_out_class;
    assign o_sig_left   = r_out_left;
    assign o_sig_right  = r_out_right;
    assign o_score      = r_out_score;

    `LMPC_ASSERT_DLY(a_result_latency, RESULT_LAT, accept, o_strobe, "item lost in pipeline")
    `LMPC_ASSERT_IMP(a_winner_zero_k, r_ctl[2].valid, r_s2_k[r_ctl[2].cls] == '0, "winner not max")
    `LMPC_ASSERT_IMP(a_winner_exp_one, r_ctl[S_EXP_OUT].valid, w_cls_e[r_ctl[S_EXP_OUT].cls] == ONE_Q16, "winner exp not one")
    `LMPC_ASSERT_IMP(a_lane_class, o_strobe && o_lane_flag, o_lane_class != CLASS_BG, "lane with background class")
    `LMPC_ASSERT_IMP(a_non_lane_zero, o_strobe && !o_lane_flag, o_lane_class == CLASS_BG && o_sig_left == '0 && o_sig_right == '0 && o_score == '0, "non-lane fields not zero")

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the lane map pixel classifier pipeline.
`timescale 1ns / 1ps

module tb;

    localparam int MAX_ROWS       = 4096;
    localparam int CLASSES        = lmpc_pkg::NUM_CLASS;
    localparam int ROW_W          = lmpc_pkg::ROW_W;
    localparam int LOGIT_W        = lmpc_pkg::LOGIT_W;
    localparam int PIPE_LATENCY   = 25;
    localparam int DRAIN_CYCLES   = 400;
    localparam int LIMIT_CYCLES   = 200000;
    localparam int RAND_PHASES    = 6;
    localparam int RAND_PER_PHASE = 190;
    localparam int LOGIT_MAX      = 32767;
    localparam int LOGIT_MIN      = -32768;

    // Index 3 is not a register; writes to it must leave the block unchanged.
    localparam logic [lmpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    localparam logic [63:0] Q16_ONE   = 64'd65536;
    localparam logic [63:0] Q16_HALF  = 64'd32768;
    localparam logic [63:0] LOG2E_Q16 = 64'd94548;
    // 2^(-2^b/256) in Q0.16, entry b for fraction bit b.
    localparam logic [7:0][15:0] FRAC_STEP = {
        16'd46341, 16'd55109, 16'd60097, 16'd62757,
        16'd64132, 16'd64830, 16'd65182, 16'd65359
    };

    typedef struct packed {
        logic [ROW_W-1:0]                row;
        logic [CLASSES-1:0][LOGIT_W-1:0] cls;
        logic [LOGIT_W-1:0]              left;
        logic [LOGIT_W-1:0]              right;
    } pixel_t;

    typedef struct packed {
        logic        flag;
        logic [1:0]  cls;
        logic [15:0] sig_left;
        logic [15:0] sig_right;
        logic [15:0] score;
    } lane_result_t;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    logic [ROW_W-1:0]                i_row;
    logic [LOGIT_W-1:0]              i_class0_logit;
    logic [LOGIT_W-1:0]              i_class1_logit;
    logic [LOGIT_W-1:0]              i_class2_logit;
    logic [LOGIT_W-1:0]              i_class3_logit;
    logic [LOGIT_W-1:0]              i_left_logit;
    logic [LOGIT_W-1:0]              i_right_logit;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [lmpc_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [lmpc_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            o_strobe;
    logic                            o_lane_flag;
    logic [1:0]                      o_lane_class;
    logic [15:0]                     o_sig_left;
    logic [15:0]                     o_sig_right;
    logic [15:0]                     o_score;

    logic [12:0] cfg_height;
    logic [11:0] cfg_omit;
    logic [15:0] cfg_thresh;

    lane_result_t lane_verdicts [$];
    int           err_count;
    int           cycle_count;
    bit           steady;

    lane_map_pixel_classifier #(
        .MAX_ROWS(MAX_ROWS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_row          (i_row),
        .i_class0_logit (i_class0_logit),
        .i_class1_logit (i_class1_logit),
        .i_class2_logit (i_class2_logit),
        .i_class3_logit (i_class3_logit),
        .i_left_logit   (i_left_logit),
        .i_right_logit  (i_right_logit),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_lane_flag    (o_lane_flag),
        .o_lane_class   (o_lane_class),
        .o_sig_left     (o_sig_left),
        .o_sig_right    (o_sig_right),
        .o_score        (o_score)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // exp(-mag/256) in Q1.16: split mag*log2(e) into shift and fraction.
    function automatic logic [16:0] exp_neg_q16(input logic [15:0] mag);
        logic [63:0] u;
        logic [63:0] v;
        logic [7:0]  f;
        int          n;
        u = (64'(mag) * LOG2E_Q16 + Q16_HALF) >> 16;
        n = int'(u >> 8);
        f = u[7:0];
        v = Q16_ONE;
        for (int b = 0; b < 8; b++) begin
            if (f[b]) begin
                v = (v * 64'(FRAC_STEP[b]) + Q16_HALF) >> 16;
            end
        end
        if (n > 16) begin
            return 17'd0;
        end
        return 17'(v >> n);
    endfunction

    function automatic logic [15:0] sigmoid_q16(input logic [LOGIT_W-1:0] x);
        int          xs;
        logic [15:0] mag;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] q;
        xs = int'($signed(x));
        mag = (xs < 0) ? 16'(-xs) : 16'(xs);
        e = 64'(exp_neg_q16(mag));
        d = Q16_ONE + e;
        num = (xs >= 0) ? Q16_ONE * Q16_ONE : e * Q16_ONE;
        q = (num + d / 2) / d;
        return (q > 64'd65535) ? 16'hFFFF : q[15:0];
    endfunction

    // First maximal class and its unsaturated softmax probability.
    function automatic void softmax_winner(input pixel_t px, output int w,
                                           output logic [16:0] p);
        int          lg [CLASSES];
        int          m;
        logic [16:0] e [CLASSES];
        logic [63:0] s;
        logic [63:0] q;
        for (int i = 0; i < CLASSES; i++) begin
            lg[i] = int'($signed(px.cls[i]));
        end
        m = lg[0];
        w = 0;
        for (int i = 1; i < CLASSES; i++) begin
            if (lg[i] > m) begin
                m = lg[i];
                w = i;
            end
        end
        s = 64'd0;
        for (int i = 0; i < CLASSES; i++) begin
            e[i] = exp_neg_q16(16'(m - lg[i]));
            s += 64'(e[i]);
        end
        q = (64'(e[w]) * Q16_ONE + s / 2) / s;
        p = 17'(q);
    endfunction

    function automatic lane_result_t classify_pixel(input pixel_t px);
        lane_result_t res;
        int           w;
        logic [16:0]  p;
        int           h;
        softmax_winner(px, w, p);
        h = (int'(cfg_height) > MAX_ROWS) ? MAX_ROWS : int'(cfg_height);
        res = '0;
        if (w != 0 && p >= 17'(cfg_thresh) && int'(px.row) + int'(cfg_omit) < h) begin
            res.flag      = 1'b1;
            res.cls       = 2'(w);
            res.sig_left  = sigmoid_q16(px.left);
            res.sig_right = sigmoid_q16(px.right);
            res.score     = (p > 17'd65535) ? 16'hFFFF : p[15:0];
        end
        return res;
    endfunction

    function automatic pixel_t mk_pixel(input int row, input int c0, input int c1,
                                        input int c2, input int c3, input int lt,
                                        input int rt);
        pixel_t px;
        px.row    = ROW_W'(row);
        px.cls[0] = LOGIT_W'(c0);
        px.cls[1] = LOGIT_W'(c1);
        px.cls[2] = LOGIT_W'(c2);
        px.cls[3] = LOGIT_W'(c3);
        px.left   = LOGIT_W'(lt);
        px.right  = LOGIT_W'(rt);
        return px;
    endfunction

    // Mostly pixels near a shared level with one boosted class, so that the
    // threshold and row tests decide; some ties, dominant winners and noise.
    function automatic pixel_t random_pixel();
        pixel_t px;
        int     lg [CLASSES];
        int     sel;
        int     base;
        int     winner;
        int     other;
        int     m;
        int     h;
        sel = int'($urandom_range(99));
        h = (int'(cfg_height) > MAX_ROWS) ? MAX_ROWS : int'(cfg_height);
        if (h > 0 && $urandom_range(99) < 75) begin
            px.row = ROW_W'($urandom_range(h - 1));
        end else begin
            px.row = ROW_W'($urandom);
        end
        if (sel < 10) begin
            for (int i = 0; i < CLASSES; i++) begin
                px.cls[i] = LOGIT_W'($urandom);
            end
        end else begin
            base = int'($urandom_range(16383)) - 8192;
            for (int i = 0; i < CLASSES; i++) begin
                lg[i] = base + int'($urandom_range(2047)) - 1024;
            end
            winner = int'($urandom_range(CLASSES - 1));
            if (sel < 25) begin
                other = int'($urandom_range(CLASSES - 1));
                m = lg[0];
                for (int i = 1; i < CLASSES; i++) begin
                    if (lg[i] > m) begin
                        m = lg[i];
                    end
                end
                lg[winner] = m;
                lg[other]  = m;
            end else if (sel < 35) begin
                // Far enough above the rest that the others' exp rounds to zero.
                lg[winner] = base + 4200 + int'($urandom_range(3000));
            end else begin
                lg[winner] += int'($urandom_range(1536));
            end
            for (int i = 0; i < CLASSES; i++) begin
                px.cls[i] = LOGIT_W'(lg[i]);
            end
        end
        if ($urandom_range(99) < 15) begin
            px.left  = LOGIT_W'($urandom);
            px.right = LOGIT_W'($urandom);
        end else begin
            px.left  = LOGIT_W'(int'($urandom_range(4095)) - 2048);
            px.right = LOGIT_W'(int'($urandom_range(4095)) - 2048);
        end
        return px;
    endfunction

    task automatic flag_mismatch(input string what, input longint want, input longint got);
        $display("%0t mismatch %s: expected %0d got %0d", $time, what, want, got);
        err_count++;
    endtask

    task automatic push_pixel(input pixel_t px);
        int           gap;
        lane_result_t verdict;
        gap = 0;
        if (!steady && $urandom_range(99) < 15) begin
            gap = int'($urandom_range(4, 1));
        end
        if (gap > 0) begin
            @(negedge i_clk) start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start          <= 1'b1;
        i_row          <= px.row;
        i_class0_logit <= px.cls[0];
        i_class1_logit <= px.cls[1];
        i_class2_logit <= px.cls[2];
        i_class3_logit <= px.cls[3];
        i_left_logit   <= px.left;
        i_right_logit  <= px.right;
        do @(posedge i_clk); while (busy !== 1'b0);
        verdict = classify_pixel(px);
        lane_verdicts = {lane_verdicts, verdict};
    endtask

    task automatic write_reg(input logic [lmpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lmpc_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            lmpc_pkg::CFG_MAP_HEIGHT:   cfg_height = data[12:0];
            lmpc_pkg::CFG_OMIT_ROWS:    cfg_omit   = data[11:0];
            lmpc_pkg::CFG_SCORE_THRESH: cfg_thresh = data;
            default: ;
        endcase
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // Stops issuing items and lets every pending result come out.
    task automatic drain_pipeline();
        int waited;
        @(negedge i_clk) start <= 1'b0;
        waited = 0;
        while (lane_verdicts.size() != 0 && waited < DRAIN_CYCLES) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_config(input int height, input int omit, input int thresh);
        drain_pipeline();
        write_reg(lmpc_pkg::CFG_MAP_HEIGHT, 16'(height));
        write_reg(lmpc_pkg::CFG_OMIT_ROWS, 16'(omit));
        write_reg(lmpc_pkg::CFG_SCORE_THRESH, 16'(thresh));
    endtask

    task automatic test_reset_defaults();
        push_pixel(mk_pixel(0, LOGIT_MIN, LOGIT_MAX, LOGIT_MIN, LOGIT_MIN,
                            LOGIT_MAX, LOGIT_MIN));
        push_pixel(mk_pixel(4095, LOGIT_MIN, LOGIT_MIN, LOGIT_MIN, LOGIT_MIN,
                            LOGIT_MIN, LOGIT_MAX));
        push_pixel(mk_pixel(10, LOGIT_MAX, 0, 0, 0, 0, 0));
        push_pixel(mk_pixel(479, 0, 0, 0, 512, 0, 0));
        push_pixel(mk_pixel(480, 0, 0, 4096, 0, 300, -300));
    endtask

    task automatic test_ties();
        push_pixel(mk_pixel(5, LOGIT_MIN, 768, 768, LOGIT_MIN, -1, 1));
        push_pixel(mk_pixel(6, -512, -512, 1024, 1024, 2560, -2560));
        push_pixel(mk_pixel(7, 2048, 0, 0, 2048, 128, 128));
        push_pixel(mk_pixel(8, 4660, 4660, 4660, 4660, -128, -128));
    endtask

    task automatic test_threshold_edge();
        pixel_t      px;
        int          w;
        logic [16:0] p;
        px = mk_pixel(0, 0, 0, 256, 0, 100, -100);
        softmax_winner(px, w, p);
        // Probability equal to the threshold passes, one below it fails.
        set_config(480, 0, int'(p));
        push_pixel(px);
        set_config(480, 0, int'(p) + 1);
        push_pixel(px);
        set_config(480, 0, 0);
        push_pixel(mk_pixel(1, 0, 1, 0, 0, 1000, -1000));
        set_config(480, 0, 65535);
        push_pixel(mk_pixel(2, LOGIT_MIN, LOGIT_MAX, LOGIT_MIN, LOGIT_MIN, 50, 60));
        push_pixel(mk_pixel(3, 0, 2800, 0, 0, 50, 60));
    endtask

    task automatic test_row_limits();
        set_config(100, 10, 0);
        push_pixel(mk_pixel(89, -256, 1024, 0, 0, 700, -700));
        push_pixel(mk_pixel(90, -256, 1024, 0, 0, 700, -700));
        push_pixel(mk_pixel(4095, -256, 1024, 0, 0, 700, -700));
        // Omitting every row but the first of a full-height map.
        set_config(4096, 4095, 0);
        push_pixel(mk_pixel(0, 0, 0, 0, 900, -40, 40));
        push_pixel(mk_pixel(1, 0, 0, 0, 900, -40, 40));
    endtask

    task automatic test_height_extremes();
        set_config(0, 0, 0);
        push_pixel(mk_pixel(0, 0, 0, 900, 0, 1, 1));
        // Heights above the maximum are limited to it.
        set_config(8191, 0, 0);
        push_pixel(mk_pixel(4095, 0, 0, 900, 0, 1, 1));
        set_config(1, 0, 0);
        push_pixel(mk_pixel(0, 0, 900, 0, 0, -5000, 5000));
        push_pixel(mk_pixel(1, 0, 900, 0, 0, -5000, 5000));
        // Bits above each register's width are dropped.
        set_config(16'hE005, 16'hF003, 0);
        write_reg(CFG_SPARE_IDX, 16'hFFFF);
        push_pixel(mk_pixel(1, 0, 0, 0, 900, 3, 3));
        push_pixel(mk_pixel(2, 0, 0, 0, 900, 3, 3));
    endtask

    task automatic test_random_phases();
        int h;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: set_config(480, 0, 32768);
                1: set_config(4096, 0, 0);
                2: begin
                    h = int'($urandom_range(MAX_ROWS, 1));
                    set_config(h, int'($urandom_range(h / 4)), int'($urandom_range(50000, 8000)));
                end
                3: set_config(16'hFFFF, 200, 65535);
                4: set_config(int'($urandom_range(600, 1)), int'($urandom_range(100)),
                              int'($urandom_range(65535)));
                default: set_config(int'($urandom_range(65535)), int'($urandom_range(65535)),
                                    int'($urandom_range(65535)));
            endcase
            // One phase runs with no idle cycles at all.
            steady = (ph == 2);
            repeat (RAND_PER_PHASE) push_pixel(random_pixel());
        end
        steady = 1'b0;
    endtask

    always @(posedge i_clk) begin : result_check
        lane_result_t want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (lane_verdicts.size() == 0) begin
                flag_mismatch("result with no pending item", 0, 1);
            end else begin
                want = lane_verdicts.pop_front();
                if (o_lane_flag !== want.flag)
                    flag_mismatch("lane_flag", want.flag, o_lane_flag);
                if (o_lane_class !== want.cls)
                    flag_mismatch("lane_class", want.cls, o_lane_class);
                if (o_sig_left !== want.sig_left)
                    flag_mismatch("sig_left", want.sig_left, o_sig_left);
                if (o_sig_right !== want.sig_right)
                    flag_mismatch("sig_right", want.sig_right, o_sig_right);
                if (o_score !== want.score)
                    flag_mismatch("score", want.score, o_score);
            end
        end else if (i_rst_n === 1'b1 && o_strobe !== 1'b0) begin
            flag_mismatch("strobe unknown", 0, 1);
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: errors");
        $finish;
    end

    initial begin : run_tests
        err_count      = 0;
        steady         = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_row          = '0;
        i_class0_logit = '0;
        i_class1_logit = '0;
        i_class2_logit = '0;
        i_class3_logit = '0;
        i_left_logit   = '0;
        i_right_logit  = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        cfg_height     = 13'd480;
        cfg_omit       = 12'd0;
        cfg_thresh     = 16'd32768;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_reset_defaults();
        test_ties();
        test_threshold_edge();
        test_row_limits();
        test_height_extremes();
        test_random_phases();

        drain_pipeline();
        if (lane_verdicts.size() != 0)
            flag_mismatch("results never arrived", lane_verdicts.size(), 0);
        if (err_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/lmpc_pkg.sv
rtl/core/lmpc_exp.sv
rtl/core/lmpc_div.sv
rtl/core/lane_map_pixel_classifier.sv
test/tb.sv
